// ----- rtl/core/can_tx_buffer_spi_frame_builder_defines.svh -----
// assertion macros shared by the checker
`ifndef CAN_TX_BUFFER_SPI_FRAME_BUILDER_DEFINES_SVH
`define CAN_TX_BUFFER_SPI_FRAME_BUILDER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CTBSFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ctbsfb check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define CTBSFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ctbsfb check failed");

`endif

// ----- rtl/core/ctbsfb_pkg.sv -----
// shared constants and types of the tx buffer spi frame builder
`timescale 1ns / 1ps

package ctbsfb_pkg;

  localparam int NumTxBuffers = 3;
  localparam int HdrBytes = 6;
  localparam int MaxData = 8;
  localparam int QDepth = 2;
  localparam int QAw = 1;

  localparam logic [7:0] OpLoadTxb = 8'h40;
  localparam logic [7:0] OpRts = 8'h80;
  localparam logic [7:0] SidlExtFlag = 8'h08;
  localparam logic [7:0] DlcRemoteFlag = 8'h40;

  // one message after classification
  typedef struct packed {
    logic                 all_busy;
    logic [1:0]           buf_idx;
    logic [HdrBytes-1:0][7:0] hdr;
    logic [3:0]           ndata;
    logic [63:0]          payload;
    logic [7:0]           rts;
  } desc_t;

  // queue handshake toward the back end
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// ----- rtl/core/ctbsfb_front.sv -----
// front end: picks the free buffer and builds the frame header bytes
`timescale 1ns / 1ps

module ctbsfb_front (
  input  logic [10:0]         std_id_i,
  input  logic [17:0]         ext_id_i,
  input  logic                extended_i,
  input  logic                remote_i,
  input  logic [3:0]          data_length_i,
  input  logic [63:0]         payload_i,
  input  logic [2:0]          busy_mask_i,
  output ctbsfb_pkg::desc_t   desc_o
);

  logic       found;
  logic [1:0] sel;
  logic [7:0] sidl;
  logic [7:0] eid8;
  logic [7:0] eid0;

  // lowest free buffer wins, so scan from the top down
  always_comb begin
    found = 1'b0;
    sel   = 2'd0;
    for (int n = ctbsfb_pkg::NumTxBuffers - 1; n >= 0; n--) begin
      if (!busy_mask_i[n]) begin
        found = 1'b1;
        sel   = 2'(n);
      end
    end
  end

  always_comb begin
    sidl = {std_id_i[2:0], 5'd0};
    eid8 = 8'd0;
    eid0 = 8'd0;
    if (extended_i) begin
      sidl = sidl | ctbsfb_pkg::SidlExtFlag | {6'd0, ext_id_i[17:16]};
      eid8 = ext_id_i[15:8];
      eid0 = ext_id_i[7:0];
    end
  end

  always_comb begin
    desc_o.all_busy = !found;
    desc_o.buf_idx  = sel;
    desc_o.hdr[0]   = ctbsfb_pkg::OpLoadTxb | {5'd0, sel, 1'b0};
    desc_o.hdr[1]   = std_id_i[10:3];
    desc_o.hdr[2]   = sidl;
    desc_o.hdr[3]   = eid8;
    desc_o.hdr[4]   = eid0;
    desc_o.hdr[5]   = {4'd0, data_length_i} | (remote_i ? ctbsfb_pkg::DlcRemoteFlag : 8'd0);
    desc_o.ndata    = data_length_i[3] ? 4'(ctbsfb_pkg::MaxData) : data_length_i;
    desc_o.payload  = payload_i;
    desc_o.rts      = ctbsfb_pkg::OpRts | (8'd1 << sel);
  end

endmodule

// ----- rtl/core/ctbsfb_queue.sv -----
// two-entry message queue between front and back end
`timescale 1ns / 1ps

module ctbsfb_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  ctbsfb_pkg::desc_t          push_desc_i,
  input  logic                       pop_i,
  output ctbsfb_pkg::desc_t          pop_desc_o,
  output ctbsfb_pkg::q_status_t      status_o
);

  ctbsfb_pkg::desc_t mem_q [ctbsfb_pkg::QDepth];
  logic [ctbsfb_pkg::QAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [ctbsfb_pkg::QAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [ctbsfb_pkg::QAw:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q + (push_i ? 1'b1 : 1'b0);
    rd_ptr_d = rd_ptr_q + (pop_i ? 1'b1 : 1'b0);
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  assign pop_desc_o     = mem_q[rd_ptr_q];
  assign status_o.valid = (count_q != '0);
  assign status_o.full  = (count_q == (ctbsfb_pkg::QAw+1)'(ctbsfb_pkg::QDepth));

endmodule

// ----- rtl/core/ctbsfb_back.sv -----
// back end: walks one message out as spi words, one per cycle unless the output stalls
`timescale 1ns / 1ps

module ctbsfb_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctbsfb_pkg::q_status_t  q_status_i,
  input  ctbsfb_pkg::desc_t      desc_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             spi_byte_o,
  output logic                   end_of_transfer_o,
  output logic [1:0]             buffer_used_o,
  output logic                   status_o,
  output logic                   last_o
);

  logic [3:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       eot_q, eot_d;
  logic [1:0] bufu_q;
  logic       st_q, st_d;
  logic       last_q, last_d;
  logic       fire;
  logic [3:0] data_off;
  logic [3:0] data_end;

  assign fire     = q_status_i.valid && (!out_valid_q || !out_stall_i);
  assign data_off = idx_q - 4'(ctbsfb_pkg::HdrBytes);
  assign data_end = 4'(ctbsfb_pkg::HdrBytes) + desc_i.ndata;

  always_comb begin
    byte_d = 8'd0;
    eot_d  = 1'b0;
    st_d   = 1'b0;
    last_d = 1'b0;
    if (desc_i.all_busy) begin
      st_d   = 1'b1;
      last_d = 1'b1;
    end else if (idx_q < 4'(ctbsfb_pkg::HdrBytes)) begin
      byte_d = desc_i.hdr[idx_q[2:0]];
      eot_d  = (idx_q == 4'(ctbsfb_pkg::HdrBytes - 1)) && (desc_i.ndata == 4'd0);
    end else if (idx_q < data_end) begin
      byte_d = desc_i.payload[{data_off[2:0], 3'b000} +: 8];
      eot_d  = (idx_q == data_end - 4'd1);
    end else begin
      // request-to-send, a transfer of its own
      byte_d = desc_i.rts;
      eot_d  = 1'b1;
      last_d = 1'b1;
    end
  end

  assign pop_o = fire && last_d;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      idx_d       = last_d ? 4'd0 : idx_q + 4'd1;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_d;
      eot_q  <= eot_d;
      bufu_q <= desc_i.all_busy ? 2'd0 : desc_i.buf_idx;
      st_q   <= st_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign spi_byte_o        = byte_q;
  assign end_of_transfer_o = eot_q;
  assign buffer_used_o     = bufu_q;
  assign status_o          = st_q;
  assign last_o            = last_q;

endmodule

// ----- rtl/core/can_tx_buffer_spi_frame_builder.sv -----
// top level of the tx buffer spi frame builder
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one CAN message with the
//   busy flags of the transmit buffers. Output channel (out_valid_o /
//   out_stall_i) gives one spi word per result: the load-buffer transfer
//   (opcode, SIDH, SIDL, EID8, EID0, DLC, up to 8 data bytes) and then the
//   one-word request-to-send transfer, or a single status word when every
//   buffer is busy. last_o marks the final word of a message.
//   The first word of a message is written into a queue entry and then
//   registered into the output word when the back end takes it.
//   Throughput: the back-end sequencer sends one word per cycle while the
//   output is not stalled, and a message is 7 to 15 words (7 + min(dlc, 8),
//   or 1 when all buffers are busy); a two-entry queue lets the input take
//   the next messages meanwhile.
//   Stall: the output word holds while out_stall_i is high; in_stall_o
//   rises only when the queue holds two messages.
//   Reset: rst_ni clears the queue, the sequencer and the output valid.
`timescale 1ns / 1ps

module can_tx_buffer_spi_frame_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [10:0] std_id_i,
  input  logic [17:0] ext_id_i,
  input  logic        extended_i,
  input  logic        remote_i,
  input  logic [3:0]  data_length_i,
  input  logic [63:0] payload_i,
  input  logic [2:0]  busy_mask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  spi_byte_o,
  output logic        end_of_transfer_o,
  output logic [1:0]  buffer_used_o,
  output logic        status_o,
  output logic        last_o
);

  ctbsfb_pkg::desc_t     front_desc;
  ctbsfb_pkg::desc_t     q_desc;
  ctbsfb_pkg::q_status_t q_status;
  logic                  push;
  logic                  pop;

  ctbsfb_front u_front (
    .std_id_i      (std_id_i),
    .ext_id_i      (ext_id_i),
    .extended_i    (extended_i),
    .remote_i      (remote_i),
    .data_length_i (data_length_i),
    .payload_i     (payload_i),
    .busy_mask_i   (busy_mask_i),
    .desc_o        (front_desc)
  );

  assign in_stall_o = q_status.full;
  assign push       = in_valid_i && !q_status.full;

  ctbsfb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (front_desc),
    .pop_i       (pop),
    .pop_desc_o  (q_desc),
    .status_o    (q_status)
  );

  ctbsfb_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_status_i        (q_status),
    .desc_i            (q_desc),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .spi_byte_o        (spi_byte_o),
    .end_of_transfer_o (end_of_transfer_o),
    .buffer_used_o     (buffer_used_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

endmodule

// ----- rtl/core/ctbsfb_checker.sv -----
// port-level checks of the tx buffer spi frame builder, bound to the top
`timescale 1ns / 1ps
`include "can_tx_buffer_spi_frame_builder_defines.svh"

module ctbsfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] spi_byte_o,
  input logic       end_of_transfer_o,
  input logic [1:0] buffer_used_o,
  input logic       status_o,
  input logic       last_o
);

  // all-busy word is a lone, empty, final word
  `CTBSFB_ASSERT_NOW(a_busy_word, out_valid_o && status_o, last_o && !end_of_transfer_o && spi_byte_o == 8'd0)

  // a normal message ends with request-to-send closing its own transfer
  `CTBSFB_ASSERT_NOW(a_rts_last, out_valid_o && last_o && !status_o, end_of_transfer_o && spi_byte_o[7])

  // only existing buffers are ever named
  `CTBSFB_ASSERT_NOW(a_buf_range, out_valid_o, buffer_used_o != 2'd3)

  // a stalled word stays put
  `CTBSFB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(spi_byte_o) && $stable(last_o))

endmodule

bind can_tx_buffer_spi_frame_builder ctbsfb_checker u_ctbsfb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .spi_byte_o        (spi_byte_o),
  .end_of_transfer_o (end_of_transfer_o),
  .buffer_used_o     (buffer_used_o),
  .status_o          (status_o),
  .last_o            (last_o)
);

// ----- test/can_tx_buffer_spi_frame_builder_tb.sv -----
// self-checking testbench of the can tx buffer spi frame builder
`timescale 1ns / 1ps

module can_tx_buffer_spi_frame_builder_tb;

  typedef struct packed {
    logic [10:0] std_id;
    logic [17:0] ext_id;
    logic        extended;
    logic        remote;
    logic [3:0]  data_length;
    logic [63:0] payload;
    logic [2:0]  busy_mask;
  } can_msg_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       end_of_transfer;
    logic [1:0] buffer_used;
    logic       status;
    logic       last;
  } spi_word_t;

  typedef enum logic [1:0] {RxNoStall, RxRandomStall, RxPatternStall} rx_mode_e;

  // predicts the spi words of each message and holds them until they arrive
  class spi_word_scoreboard;
    spi_word_t   word_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void push_word(logic [7:0] b, logic eot, logic [1:0] buf_idx, logic st,
                            logic lst);
      spi_word_t w;
      w.spi_byte        = b;
      w.end_of_transfer = eot;
      w.buffer_used     = buf_idx;
      w.status          = st;
      w.last            = lst;
      word_q.push_back(w);
    endfunction

    function void note_message(can_msg_t m);
      logic [1:0]  sel;
      bit          found;
      logic [7:0]  sidl;
      logic [7:0]  eid8;
      logic [7:0]  eid0;
      logic [7:0]  dlc_byte;
      int unsigned ndata;
      found = 1'b0;
      sel   = 2'd0;
      // scan downward so the lowest free buffer wins
      for (int n = ctbsfb_pkg::NumTxBuffers - 1; n >= 0; n--) begin
        if (n < 3 && !m.busy_mask[n]) begin
          found = 1'b1;
          sel   = n[1:0];
        end
      end
      if (!found) begin
        push_word(8'h00, 1'b0, 2'd0, 1'b1, 1'b1);
        return;
      end
      ndata = (m.data_length > 4'd8) ? 8 : m.data_length;
      sidl  = {m.std_id[2:0], 5'b0};
      eid8  = 8'h00;
      eid0  = 8'h00;
      if (m.extended) begin
        sidl = sidl | ctbsfb_pkg::SidlExtFlag | {6'b0, m.ext_id[17:16]};
        eid8 = m.ext_id[15:8];
        eid0 = m.ext_id[7:0];
      end
      dlc_byte = {4'b0, m.data_length} | (m.remote ? ctbsfb_pkg::DlcRemoteFlag : 8'h00);
      push_word(ctbsfb_pkg::OpLoadTxb | {5'b0, sel, 1'b0}, 1'b0, sel, 1'b0, 1'b0);
      push_word(m.std_id[10:3], 1'b0, sel, 1'b0, 1'b0);
      push_word(sidl, 1'b0, sel, 1'b0, 1'b0);
      push_word(eid8, 1'b0, sel, 1'b0, 1'b0);
      push_word(eid0, 1'b0, sel, 1'b0, 1'b0);
      push_word(dlc_byte, ndata == 0, sel, 1'b0, 1'b0);
      for (int i = 0; i < ndata; i++) begin
        push_word(m.payload[8*i +: 8], i + 1 == ndata, sel, 1'b0, 1'b0);
      end
      // request to send is its own transfer
      push_word(ctbsfb_pkg::OpRts | (8'h01 << sel), 1'b1, sel, 1'b0, 1'b1);
    endfunction

    function void compare_field(string name, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_word(spi_word_t got);
      spi_word_t want;
      if (word_q.size() == 0) begin
        errors++;
        $display("%0t: word with none expected, expected nothing, actual %h", $time, got);
        return;
      end
      want = word_q.pop_front();
      compare_field("spi_byte", want.spi_byte, got.spi_byte);
      compare_field("end_of_transfer", want.end_of_transfer, got.end_of_transfer);
      compare_field("buffer_used", want.buffer_used, got.buffer_used);
      compare_field("status", want.status, got.status);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [10:0] std_id_i;
  logic [17:0] ext_id_i;
  logic        extended_i;
  logic        remote_i;
  logic [3:0]  data_length_i;
  logic [63:0] payload_i;
  logic [2:0]  busy_mask_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  spi_byte_o;
  logic        end_of_transfer_o;
  logic [1:0]  buffer_used_o;
  logic        status_o;
  logic        last_o;

  spi_word_scoreboard sb;
  rx_mode_e    rx_mode;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned rx_cycle;
  int unsigned idle_cycles;

  can_tx_buffer_spi_frame_builder u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .std_id_i          (std_id_i),
    .ext_id_i          (ext_id_i),
    .extended_i        (extended_i),
    .remote_i          (remote_i),
    .data_length_i     (data_length_i),
    .payload_i         (payload_i),
    .busy_mask_i       (busy_mask_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .spi_byte_o        (spi_byte_o),
    .end_of_transfer_o (end_of_transfer_o),
    .buffer_used_o     (buffer_used_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver stall pattern, plus a long hold-off when requested
  always @(negedge clk_i) begin
    rx_cycle++;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 150;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      case (rx_mode)
        RxRandomStall:  out_stall_i = ($urandom_range(0, 99) < 35);
        RxPatternStall: out_stall_i = ((rx_cycle % 11) < 4) || ((rx_cycle % 29) == 7);
        default:        out_stall_i = 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word({spi_byte_o, end_of_transfer_o, buffer_used_o, status_o, last_o});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= 1000) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic can_msg_t make_msg(logic [10:0] std_id, logic [17:0] ext_id,
                                        logic extended, logic remote,
                                        logic [3:0] dlc, logic [63:0] payload,
                                        logic [2:0] busy);
    can_msg_t m;
    m.std_id      = std_id;
    m.ext_id      = ext_id;
    m.extended    = extended;
    m.remote      = remote;
    m.data_length = dlc;
    m.payload     = payload;
    m.busy_mask   = busy;
    return m;
  endfunction

  function automatic can_msg_t random_msg();
    can_msg_t m;
    m.std_id      = 11'($urandom);
    m.ext_id      = 18'($urandom);
    m.extended    = 1'($urandom_range(0, 1));
    m.remote      = $urandom_range(0, 3) == 0;
    m.data_length = 4'($urandom_range(0, 15));
    m.payload     = {$urandom, $urandom};
    m.busy_mask   = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) m.std_id = $urandom_range(0, 1) ? 11'h7ff : 11'h000;
    return m;
  endfunction

  // drives one message at the falling edge and holds it until accepted
  task automatic send_message(can_msg_t m);
    std_id_i      = m.std_id;
    ext_id_i      = m.ext_id;
    extended_i    = m.extended;
    remote_i      = m.remote;
    data_length_i = m.data_length;
    payload_i     = m.payload;
    busy_mask_i   = m.busy_mask;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_message(m);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_random(int unsigned count, bit gaps, int hold_at);
    int unsigned burst_left;
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      send_message(random_msg());
      if (gaps) begin
        if (burst_left == 0) begin
          repeat ($urandom_range(1, 10)) @(negedge clk_i);
          burst_left = $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
  endtask

  task automatic drain();
    while (sb.word_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    sb            = new();
    rx_mode       = RxNoStall;
    hold_req      = 1'b0;
    hold_left     = 0;
    rx_cycle      = 0;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    out_stall_i   = 1'b0;
    std_id_i      = '0;
    ext_id_i      = '0;
    extended_i    = 1'b0;
    remote_i      = 1'b0;
    data_length_i = '0;
    payload_i     = '0;
    busy_mask_i   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // field extremes, every busy pattern, long dlc and remote frames
    send_message(make_msg(11'h000, 18'h00000, 1'b0, 1'b0, 4'd0, 64'h0, 3'b000));
    send_message(make_msg(11'h7ff, 18'h3ffff, 1'b1, 1'b1, 4'd15, '1, 3'b000));
    send_message(make_msg(11'h7ff, 18'h00000, 1'b0, 1'b0, 4'd8,
                          64'h0123_4567_89ab_cdef, 3'b001));
    send_message(make_msg(11'h000, 18'h3ffff, 1'b1, 1'b0, 4'd9,
                          64'hfedc_ba98_7654_3210, 3'b011));
    send_message(make_msg(11'h123, 18'h12345, 1'b1, 1'b0, 4'd3, 64'h55aa, 3'b111));
    send_message(make_msg(11'h456, 18'h2aaaa, 1'b1, 1'b0, 4'd2, 64'hbeef, 3'b010));
    send_message(make_msg(11'h2aa, 18'h15555, 1'b0, 1'b0, 4'd1, 64'h77, 3'b100));
    send_message(make_msg(11'h555, 18'h2aaaa, 1'b1, 1'b1, 4'd0, 64'h0, 3'b101));
    send_message(make_msg(11'h0f0, 18'h10000, 1'b1, 1'b0, 4'd7, 64'h1122_3344_5566_77,
                          3'b110));
    send_message(make_msg(11'h2aa, 18'h15555, 1'b0, 1'b1, 4'd1, 64'h99, 3'b000));
    send_message(make_msg(11'h7ff, 18'h3ffff, 1'b1, 1'b1, 4'd15, '1, 3'b111));
    send_message(make_msg(11'h001, 18'h30000, 1'b1, 1'b1, 4'd12, 64'h8000_0000_0000_0001,
                          3'b110));
    send_message(make_msg(11'h400, 18'h0ff00, 1'b0, 1'b1, 4'd8, 64'ha5a5_5a5a_a5a5_5a5a,
                          3'b101));
    send_message(make_msg(11'h3ff, 18'h000ff, 1'b1, 1'b0, 4'd4, 64'hcafe_f00d, 3'b011));
    drain();

    // random stalls and bursts, with a long receiver hold-off while sending
    rx_mode = RxRandomStall;
    send_random(70, 1'b1, 25);
    // sender pauses until every expected word has arrived
    drain();

    rx_mode = RxPatternStall;
    send_random(80, 1'b1, -1);

    rx_mode = RxNoStall;
    send_random(80, 1'b0, -1);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.word_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
